@@ rtl/assert_macros.svh @@
// assertion macros used by the checker file itrd_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define AST_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, held off during reset
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/itrd_pkg.sv @@
// types and constants of the radix digit converter
// used by the divider, symbol table and top level modules in rtl/, no dependencies
package itrd_pkg;

  localparam int RADIX_W     = 5;
  localparam int DIGIT_W     = 4;
  localparam int SYMBOL_W    = 8;
  localparam int NUMBER_W    = 64;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int STORE_DEPTH = 64;
  localparam int STORE_AW    = 6;
  localparam int COUNT_W     = 7;
  localparam int IN_DATA_W   = 72;

  localparam logic [RADIX_W-1:0] MIN_RADIX     = 5'd2;
  localparam logic [RADIX_W-1:0] DECIMAL_RADIX = 5'd10;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_SYM_A_LOW  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SYM_A_HIGH = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SYM_B_LOW  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SYM_B_HIGH = 3'd3;

  // "01234567", "89abcdef", "89ABCDEF", byte 0 is digit 0
  localparam logic [CFG_DATA_W-1:0] SYM_LOW_RST    = 64'h3736_3534_3332_3130;
  localparam logic [CFG_DATA_W-1:0] SYM_A_HIGH_RST = 64'h6665_6463_6261_3938;
  localparam logic [CFG_DATA_W-1:0] SYM_B_HIGH_RST = 64'h4645_4443_4241_3938;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_EMIT_RD,
    ST_EMIT_LOAD
  } state_t;

  typedef struct packed {
    logic done;
  } div_status_t;

endpackage

@@ rtl/itrd_divider.sv @@
// bit-serial restoring divider: one quotient bit per cycle
// depends on itrd_pkg
module itrd_divider #(
  parameter int VALUE_BITS = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [VALUE_BITS-1:0]        dividend,
  input  logic [itrd_pkg::RADIX_W-1:0] divisor,
  output logic [VALUE_BITS-1:0]        quotient,
  output logic [itrd_pkg::RADIX_W-1:0] remainder,
  output itrd_pkg::div_status_t        status
);

  localparam int CNT_W = $clog2(VALUE_BITS + 1);

  logic [VALUE_BITS-1:0]        dvd_r, dvd_nxt;
  logic [itrd_pkg::RADIX_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic                         done_r, done_nxt;
  logic [itrd_pkg::RADIX_W-1:0] trial;
  logic                         fits;

  // remainder stays below the divisor (at most 16), so the shifted value fits
  assign trial = {rem_r[itrd_pkg::RADIX_W-2:0], dvd_r[VALUE_BITS-1]};
  assign fits  = (trial >= divisor);

  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = CNT_W'(VALUE_BITS);
    end else if (cnt_r != '0) begin
      rem_nxt  = fits ? (trial - divisor) : trial;
      dvd_nxt  = {dvd_r[VALUE_BITS-2:0], fits};
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
  end

  assign quotient    = dvd_r;
  assign remainder   = rem_r;
  assign status.done = done_r;

endmodule

@@ rtl/itrd_symbols.sv @@
// symbol table registers and digit-to-character lookup
// depends on itrd_pkg
module itrd_symbols (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_write,
  input  logic [itrd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [itrd_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [itrd_pkg::DIGIT_W-1:0]      digit,
  input  logic                              table_sel,
  output logic [itrd_pkg::SYMBOL_W-1:0]     symbol
);

  logic [itrd_pkg::CFG_DATA_W-1:0] a_low_r, a_high_r, b_low_r, b_high_r;
  logic [itrd_pkg::CFG_DATA_W-1:0] word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_low_r  <= itrd_pkg::SYM_LOW_RST;
      a_high_r <= itrd_pkg::SYM_A_HIGH_RST;
      b_low_r  <= itrd_pkg::SYM_LOW_RST;
      b_high_r <= itrd_pkg::SYM_B_HIGH_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        itrd_pkg::REG_SYM_A_LOW:  a_low_r  <= cfg_data;
        itrd_pkg::REG_SYM_A_HIGH: a_high_r <= cfg_data;
        itrd_pkg::REG_SYM_B_LOW:  b_low_r  <= cfg_data;
        itrd_pkg::REG_SYM_B_HIGH: b_high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (table_sel) begin
      word = digit[3] ? b_high_r : b_low_r;
    end else begin
      word = digit[3] ? a_high_r : a_low_r;
    end
    symbol = word[{digit[2:0], 3'b000} +: itrd_pkg::SYMBOL_W];
  end

endmodule

@@ rtl/integer_to_radix_digits_top.sv @@
// Radix digit converter: one signed number in, its digit characters out,
// most significant first, with tlast on the final one. The radix is clamped
// to 2..MAX_RADIX; in base 10 a negative number is converted by magnitude.
// Digits come from one shared bit-serial divider, one division per digit,
// and are kept in a digit store; the characters are then sent from there,
// waiting while the sink stalls.
// in_tready is high only between items; the final character may still wait
// in the output register while the next item is accepted.
// Depends on itrd_pkg, itrd_divider and itrd_symbols.
module integer_to_radix_digits_top #(
  parameter int MAX_RADIX  = 16,
  parameter int VALUE_BITS = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [63:0] number, [68:64] radix, [71:69] zero
  input  logic [itrd_pkg::IN_DATA_W-1:0]    in_tdata,
  // [0] table_select
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [7:0] symbol
  output logic [itrd_pkg::SYMBOL_W-1:0]     out_tdata,
  output logic                              out_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [itrd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [itrd_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int RW = itrd_pkg::RADIX_W;

  itrd_pkg::state_t state_r, state_nxt;

  logic [VALUE_BITS-1:0]          quot_r, quot_nxt;
  logic [RW-1:0]                  radix_r, radix_nxt;
  logic                           sel_r, sel_nxt;
  logic [itrd_pkg::COUNT_W-1:0]   dcount_r, dcount_nxt, dcount_inc;
  logic [itrd_pkg::STORE_AW-1:0]  ecount_r, ecount_nxt;
  logic [itrd_pkg::DIGIT_W-1:0]   rd_data_r;
  logic                           out_valid_r, out_valid_nxt;
  logic [itrd_pkg::SYMBOL_W-1:0]  out_sym_r, out_sym_nxt;
  logic                           out_last_r, out_last_nxt;

  logic [itrd_pkg::DIGIT_W-1:0]   store [itrd_pkg::STORE_DEPTH];

  logic                           in_xfer;
  logic [RW-1:0]                  in_radix, radix_sat;
  logic [VALUE_BITS-1:0]          in_value, in_abs;
  logic                           div_start;
  logic [VALUE_BITS-1:0]          div_quot;
  logic [RW-1:0]                  div_rem;
  itrd_pkg::div_status_t          div_stat;
  logic [itrd_pkg::SYMBOL_W-1:0]  lut_symbol;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == itrd_pkg::ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;

  assign in_radix = in_tdata[itrd_pkg::NUMBER_W +: RW];
  assign in_value = in_tdata[VALUE_BITS-1:0];

  always_comb begin
    priority if (in_radix < itrd_pkg::MIN_RADIX) begin
      radix_sat = itrd_pkg::MIN_RADIX;
    end else if (in_radix > RW'(MAX_RADIX)) begin
      radix_sat = RW'(MAX_RADIX);
    end else begin
      radix_sat = in_radix;
    end
  end

  // decimal negatives go by magnitude, the most negative value wraps to 2^(n-1)
  assign in_abs = (in_value[VALUE_BITS-1] && radix_sat == itrd_pkg::DECIMAL_RADIX)
                  ? (~in_value + 1'b1) : in_value;

  itrd_divider #(
    .VALUE_BITS (VALUE_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (quot_r),
    .divisor   (radix_r),
    .quotient  (div_quot),
    .remainder (div_rem),
    .status    (div_stat)
  );

  itrd_symbols u_sym (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .digit     (rd_data_r),
    .table_sel (sel_r),
    .symbol    (lut_symbol)
  );

  assign dcount_inc = dcount_r + 1'b1;

  always_comb begin
    state_nxt     = state_r;
    quot_nxt      = quot_r;
    radix_nxt     = radix_r;
    sel_nxt       = sel_r;
    dcount_nxt    = dcount_r;
    ecount_nxt    = ecount_r;
    out_sym_nxt   = out_sym_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && !out_tready;
    div_start     = 1'b0;
    unique case (state_r)
      itrd_pkg::ST_IDLE: begin
        if (in_xfer) begin
          quot_nxt   = in_abs;
          radix_nxt  = radix_sat;
          sel_nxt    = in_tuser;
          dcount_nxt = '0;
          state_nxt  = itrd_pkg::ST_DIV_START;
        end
      end
      itrd_pkg::ST_DIV_START: begin
        div_start = 1'b1;
        state_nxt = itrd_pkg::ST_DIV_WAIT;
      end
      itrd_pkg::ST_DIV_WAIT: begin
        if (div_stat.done) begin
          quot_nxt   = div_quot;
          dcount_nxt = dcount_inc;
          if (div_quot != '0 &&
              dcount_inc != itrd_pkg::COUNT_W'(itrd_pkg::STORE_DEPTH)) begin
            state_nxt = itrd_pkg::ST_DIV_START;
          end else begin
            // start from the most significant digit just written
            ecount_nxt = dcount_r[itrd_pkg::STORE_AW-1:0];
            state_nxt  = itrd_pkg::ST_EMIT_RD;
          end
        end
      end
      itrd_pkg::ST_EMIT_RD: begin
        state_nxt = itrd_pkg::ST_EMIT_LOAD;
      end
      itrd_pkg::ST_EMIT_LOAD: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_sym_nxt   = lut_symbol;
          out_last_nxt  = (ecount_r == '0);
          if (ecount_r == '0) begin
            state_nxt = itrd_pkg::ST_IDLE;
          end else begin
            ecount_nxt = ecount_r - 1'b1;
            state_nxt  = itrd_pkg::ST_EMIT_RD;
          end
        end
      end
      default: state_nxt = itrd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= itrd_pkg::ST_IDLE;
      dcount_r    <= '0;
      ecount_r    <= '0;
      out_valid_r <= 1'b0;
      quot_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      dcount_r    <= dcount_nxt;
      ecount_r    <= ecount_nxt;
      out_valid_r <= out_valid_nxt;
      quot_r      <= quot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    radix_r    <= radix_nxt;
    sel_r      <= sel_nxt;
    out_sym_r  <= out_sym_nxt;
    out_last_r <= out_last_nxt;
  end

  // digit store, least significant digit at entry 0
  always_ff @(posedge clk) begin
    if (state_r == itrd_pkg::ST_DIV_WAIT && div_stat.done) begin
      store[dcount_r[itrd_pkg::STORE_AW-1:0]] <= div_rem[itrd_pkg::DIGIT_W-1:0];
    end
    if (state_r == itrd_pkg::ST_EMIT_RD) begin
      rd_data_r <= store[ecount_r];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_sym_r;
  assign out_tlast  = out_last_r;

endmodule

@@ rtl/itrd_checker.sv @@
// port-level checks of the radix digit converter, bound to the top level
// depends on assert_macros.svh and integer_to_radix_digits_top
`include "assert_macros.svh"

module itrd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  // a stalled result holds its payload
  `AST_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
            out_tvalid && $stable(out_tdata) && $stable(out_tlast))

  // one item at a time: no new transfer right after an accepted one
  `AST_NEXT(a_in_busy, clk, rst_n, in_tvalid && in_tready, !in_tready)

  // mid-run characters pending mean the converter is busy
  `AST_IMPLY(a_mid_run_busy, clk, rst_n, out_tvalid && !out_tlast, !in_tready)

  // a new item only follows a finished run
  `AST_IMPLY(a_in_after_last, clk, rst_n, in_tvalid && in_tready,
             !out_tvalid || out_tlast)

endmodule

bind integer_to_radix_digits_top itrd_checker u_itrd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

@@ sim/testbench.sv @@
// self-checking testbench for integer_to_radix_digits_top
// predicts each digit character stream in-house and checks every output transfer
// depends on itrd_pkg and the rtl top level
`timescale 1ns / 1ps

module testbench;

  localparam int MAX_RADIX  = 16;
  localparam int VALUE_BITS = 64;
  // bound for ~120 items, each up to 64 digits, plus sink stalls
  localparam int CYCLE_LIMIT = 4_000_000;

  typedef struct packed {
    logic [itrd_pkg::SYMBOL_W-1:0] symbol;
    logic                          last;
  } digit_char_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [itrd_pkg::IN_DATA_W-1:0]   in_tdata = '0;
  logic                             in_tuser = 1'b0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [itrd_pkg::SYMBOL_W-1:0]    out_tdata;
  logic                             out_tlast;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [itrd_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [itrd_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  digit_char_t                      pending_chars[$];
  logic [itrd_pkg::CFG_DATA_W-1:0]  symbol_regs [0:3];
  int                               send_gap_pct = 6;
  int                               sink_stall_pct = 82;
  int                               mismatches = 0;
  int                               cycle_count = 0;

  integer_to_radix_digits_top #(
    .MAX_RADIX (MAX_RADIX),
    .VALUE_BITS(VALUE_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // expected characters of one conversion, most significant digit first
  function automatic void predict_chars(input logic [itrd_pkg::NUMBER_W-1:0] number,
                                        input logic [itrd_pkg::RADIX_W-1:0] radix_in,
                                        input logic table_sel);
    logic [itrd_pkg::NUMBER_W-1:0]   quo;
    logic [itrd_pkg::NUMBER_W-1:0]   q;
    logic [itrd_pkg::RADIX_W-1:0]    base;
    logic [itrd_pkg::DIGIT_W-1:0]    rems [0:itrd_pkg::STORE_DEPTH-1];
    logic [itrd_pkg::CFG_DATA_W-1:0] word;
    logic [itrd_pkg::DIGIT_W-1:0]    d;
    digit_char_t                     c;
    int                              n;
    int                              k;
    base = radix_in;
    if (radix_in < itrd_pkg::MIN_RADIX) base = itrd_pkg::MIN_RADIX;
    if (radix_in > MAX_RADIX) base = itrd_pkg::RADIX_W'(MAX_RADIX);
    quo = number;
    if (quo[VALUE_BITS-1] && base == itrd_pkg::DECIMAL_RADIX) quo = -quo;
    n = 0;
    do begin
      q = quo / base;
      rems[n] = itrd_pkg::DIGIT_W'(quo - q * base);
      n++;
      quo = q;
    end while (quo != 0 && n < itrd_pkg::STORE_DEPTH);
    for (k = n - 1; k >= 0; k--) begin
      d = rems[k];
      if (table_sel)
        word = d[3] ? symbol_regs[itrd_pkg::REG_SYM_B_HIGH]
                    : symbol_regs[itrd_pkg::REG_SYM_B_LOW];
      else
        word = d[3] ? symbol_regs[itrd_pkg::REG_SYM_A_HIGH]
                    : symbol_regs[itrd_pkg::REG_SYM_A_LOW];
      c.symbol = word[d[2:0]*8 +: 8];
      c.last = (k == 0);
      pending_chars.push_back(c);
    end
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] expv,
                               input logic [63:0] actv);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s: expected %h, got %h", what, expv, actv);
  endtask

  // output side: random backpressure and a check of each transfer
  always @(posedge clk) begin
    digit_char_t exp_c;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_chars.size() == 0) begin
        flag_mismatch("unexpected character", 64'd0, {55'd0, out_tlast, out_tdata});
      end else begin
        exp_c = pending_chars.pop_front();
        if (out_tdata !== exp_c.symbol) flag_mismatch("symbol", exp_c.symbol, out_tdata);
        if (out_tlast !== exp_c.last) flag_mismatch("tlast", exp_c.last, out_tlast);
      end
    end
    out_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // leaves tvalid high after the transfer so back-to-back items need no toggle
  task automatic send_number(input logic [itrd_pkg::NUMBER_W-1:0] number,
                             input logic [itrd_pkg::RADIX_W-1:0] radix_in,
                             input logic table_sel);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, radix_in, number};
    in_tuser  <= table_sel;
    do @(posedge clk); while (!in_tready);
    predict_chars(number, radix_in, table_sel);
  endtask

  task automatic finish_phase();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_chars.size() != 0) @(posedge clk);
  endtask

  task automatic load_symbol_tables(input logic [itrd_pkg::CFG_DATA_W-1:0] a_lo,
                                    input logic [itrd_pkg::CFG_DATA_W-1:0] a_hi,
                                    input logic [itrd_pkg::CFG_DATA_W-1:0] b_lo,
                                    input logic [itrd_pkg::CFG_DATA_W-1:0] b_hi);
    logic [itrd_pkg::CFG_INDEX_W-1:0] regs [0:3];
    logic [itrd_pkg::CFG_DATA_W-1:0]  vals [0:3];
    int i;
    regs[0] = itrd_pkg::REG_SYM_A_LOW;
    regs[1] = itrd_pkg::REG_SYM_A_HIGH;
    regs[2] = itrd_pkg::REG_SYM_B_LOW;
    regs[3] = itrd_pkg::REG_SYM_B_HIGH;
    vals[0] = a_lo;
    vals[1] = a_hi;
    vals[2] = b_lo;
    vals[3] = b_hi;
    for (i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      symbol_regs[regs[i]] = vals[i];
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [itrd_pkg::NUMBER_W-1:0] random_number();
    logic [itrd_pkg::NUMBER_W-1:0] raw;
    int w;
    raw = {$urandom, $urandom};
    w = $urandom_range(1, 64);
    case ($urandom_range(0, 5))
      0: return raw;
      1, 2: return raw >> (64 - w);
      3: return -(raw >> (64 - w));
      4: return itrd_pkg::NUMBER_W'($urandom_range(0, 20));
      default: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return {1'b1, 63'd0};
          2: return {1'b0, {63{1'b1}}};
          default: return '1;
        endcase
      end
    endcase
  endfunction

  // reset tables: zero, extremes and the radix-10 magnitude rule
  task automatic test_reset_tables();
    send_number('0, itrd_pkg::DECIMAL_RADIX, 1'b0);
    send_number('0, itrd_pkg::MIN_RADIX, 1'b1);
    send_number({1'b0, {63{1'b1}}}, itrd_pkg::DECIMAL_RADIX, 1'b0);
    send_number({1'b1, 63'd0}, itrd_pkg::DECIMAL_RADIX, 1'b1);
    send_number('1, itrd_pkg::DECIMAL_RADIX, 1'b0);
    send_number('1, itrd_pkg::MIN_RADIX, 1'b0);
    send_number(64'h0123_4567_89AB_CDEF, itrd_pkg::RADIX_W'(16), 1'b1);
    finish_phase();
  endtask

  // radices 3 to 15 plus out-of-range values that saturate
  task automatic test_radix_sweep();
    int r;
    for (r = 3; r <= 15; r++)
      send_number({$urandom, $urandom}, itrd_pkg::RADIX_W'(r), r[0]);
    send_number(64'h0000_0000_0BAD_F00D, itrd_pkg::RADIX_W'(0), 1'b0);
    send_number(64'hFFFF_FFFF_FFFF_FF85, itrd_pkg::RADIX_W'(1), 1'b1);
    send_number(64'h0123_4567_89AB_CDEF, itrd_pkg::RADIX_W'(17), 1'b0);
    send_number(64'hFEDC_BA98_7654_3210, itrd_pkg::RADIX_W'(31), 1'b1);
    finish_phase();
  endtask

  task automatic test_table_extremes();
    load_symbol_tables('0, '0, '0, '0);
    send_number(64'h0123_4567_89AB_CDEF, itrd_pkg::RADIX_W'(16), 1'b0);
    finish_phase();
    load_symbol_tables('1, '1, '1, '1);
    send_number(64'hFEDC_BA98_7654_3210, itrd_pkg::RADIX_W'(16), 1'b1);
    finish_phase();
  endtask

  task automatic test_random_numbers(input int count, input int gap_pct,
                                     input int stall_pct);
    logic [itrd_pkg::RADIX_W-1:0] r;
    int i;
    send_gap_pct = gap_pct;
    sink_stall_pct = stall_pct;
    load_symbol_tables({$urandom, $urandom}, {$urandom, $urandom},
                       {$urandom, $urandom}, {$urandom, $urandom});
    for (i = 0; i < count; i++) begin
      // mostly legal radices, now and then the whole 5-bit field
      if ($urandom_range(0, 9) == 0) r = itrd_pkg::RADIX_W'($urandom_range(0, 31));
      else r = itrd_pkg::RADIX_W'($urandom_range(2, 16));
      send_number(random_number(), r, 1'($urandom_range(0, 1)));
    end
    finish_phase();
  endtask

  initial begin
    symbol_regs[itrd_pkg::REG_SYM_A_LOW]  = itrd_pkg::SYM_LOW_RST;
    symbol_regs[itrd_pkg::REG_SYM_A_HIGH] = itrd_pkg::SYM_A_HIGH_RST;
    symbol_regs[itrd_pkg::REG_SYM_B_LOW]  = itrd_pkg::SYM_LOW_RST;
    symbol_regs[itrd_pkg::REG_SYM_B_HIGH] = itrd_pkg::SYM_B_HIGH_RST;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_tables();
    test_radix_sweep();
    test_table_extremes();
    test_random_numbers(31, 6, 82);
    test_random_numbers(31, 82, 6);
    test_random_numbers(31, 0, 0);

    // catch stray characters after the last expected one
    repeat (2 * (VALUE_BITS + 4)) @(posedge clk);
    if (mismatches == 0 && pending_chars.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/itrd_pkg.sv
rtl/itrd_divider.sv
rtl/itrd_symbols.sv
rtl/integer_to_radix_digits_top.sv
rtl/itrd_checker.sv
sim/testbench.sv
